// ===== rtl/psimd_pkg.sv =====
// ----------------------------------------------------------------------------
// psimd_pkg: shared types for the packed SIMD add/subtract ALU
// Operation codes, lane control and the transaction payload structs.
// ----------------------------------------------------------------------------
package psimd_pkg;

  // lane widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned HalfW = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumBytes = DataW / ByteW;
  localparam int unsigned NumHalves = DataW / HalfW;

  // operation codes
  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_SUB  = 3'd1,
    FUNC_HADD = 3'd2,
    FUNC_HSUB = 3'd3,
    FUNC_QADD = 3'd4,
    FUNC_QSUB = 3'd5
  } psimd_func_e;

  // what a lane does with its exact sum or difference
  typedef enum logic [1:0] {
    MODE_WRAP,
    MODE_HALVE,
    MODE_SAT
  } psimd_mode_e;

  // control shared by all lanes
  typedef struct packed {
    logic        is_sub;
    logic        lanes_signed;
    psimd_mode_e mode;
  } psimd_lane_ctrl_t;

  // input transaction
  typedef struct packed {
    logic [2:0]       func;
    logic             lane_is_halfword;
    logic             lanes_signed;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } psimd_in_t;

  // result transaction
  typedef struct packed {
    logic [DataW-1:0]    packed_result;
    logic [NumBytes-1:0] ge_flags;
    logic                ge_valid;
  } psimd_out_t;

endpackage

// ===== rtl/psimd_lane.sv =====
// ----------------------------------------------------------------------------
// psimd_lane: one add/subtract lane
// Forms the exact sum or difference of one lane and wraps, halves or
// saturates it. Also gives the GE flag of the lane.
// ----------------------------------------------------------------------------
module psimd_lane
  import psimd_pkg::*;
#(
  parameter int unsigned W = ByteW
) (
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  psimd_lane_ctrl_t ctrl_i,
  output logic [W-1:0]     res_o,
  output logic             ge_o
);

  logic signed [W+1:0] xe;
  logic signed [W+1:0] ye;
  logic signed [W+1:0] exact;
  logic signed [W+1:0] hi_v;
  logic signed [W+1:0] lo_v;
  logic                xs;
  logic                ys;

  // sign or zero extend both operands to two guard bits
  assign xs   = ctrl_i.lanes_signed & a_i[W-1];
  assign ys   = ctrl_i.lanes_signed & b_i[W-1];
  assign xe   = {{2{xs}}, a_i};
  assign ye   = {{2{ys}}, b_i};
  assign exact = ctrl_i.is_sub ? (xe - ye) : (xe + ye);

  // lane range limits
  assign hi_v = ctrl_i.lanes_signed ? {3'b000, {(W-1){1'b1}}} : {2'b00, {W{1'b1}}};
  assign lo_v = ctrl_i.lanes_signed ? {3'b111, {(W-1){1'b0}}} : '0;

  // unsigned add flags the carry out, everything else a non-negative result
  assign ge_o = (!ctrl_i.lanes_signed && !ctrl_i.is_sub) ? exact[W] : !exact[W+1];

  // result selection
  always_comb begin
    unique case (ctrl_i.mode)
      MODE_WRAP:  res_o = exact[W-1:0];
      MODE_HALVE: res_o = exact[W:1];
      MODE_SAT: begin
        if (exact < lo_v) begin
          res_o = lo_v[W-1:0];
        end else if (exact > hi_v) begin
          res_o = hi_v[W-1:0];
        end else begin
          res_o = exact[W-1:0];
        end
      end
      default:    res_o = exact[W-1:0];
    endcase
  end

endmodule

// ===== rtl/psimd_datapath.sv =====
// ----------------------------------------------------------------------------
// psimd_datapath: lane array and result assembly
// Decodes the operation, runs four byte lanes and two halfword lanes side by
// side and packs the selected lane width into one result.
// ----------------------------------------------------------------------------
module psimd_datapath
  import psimd_pkg::*;
(
  input  psimd_in_t  in_i,
  output psimd_out_t out_o
);

  psimd_lane_ctrl_t    ctrl;
  logic                func_known;
  logic                plain;
  logic [DataW-1:0]    byte_res;
  logic [DataW-1:0]    half_res;
  logic [NumBytes-1:0] byte_ge;
  logic [NumHalves-1:0] half_ge;
  logic [NumBytes-1:0] half_ge_wide;

  // operation decode
  always_comb begin
    ctrl.is_sub       = in_i.func[0];
    ctrl.lanes_signed = in_i.lanes_signed;
    func_known        = 1'b1;
    plain             = 1'b0;
    unique case (in_i.func)
      FUNC_ADD, FUNC_SUB: begin
        ctrl.mode = MODE_WRAP;
        plain     = 1'b1;
      end
      FUNC_HADD, FUNC_HSUB: ctrl.mode = MODE_HALVE;
      FUNC_QADD, FUNC_QSUB: ctrl.mode = MODE_SAT;
      default: begin
        ctrl.mode  = MODE_WRAP;
        func_known = 1'b0;
      end
    endcase
  end

  // byte lanes
  for (genvar i = 0; i < NumBytes; i++) begin : g_byte
    psimd_lane #(.W(ByteW)) u_lane (
      .a_i   (in_i.operand_a[i*ByteW +: ByteW]),
      .b_i   (in_i.operand_b[i*ByteW +: ByteW]),
      .ctrl_i(ctrl),
      .res_o (byte_res[i*ByteW +: ByteW]),
      .ge_o  (byte_ge[i])
    );
  end

  // halfword lanes, each flag covers both of its bytes
  for (genvar h = 0; h < NumHalves; h++) begin : g_half
    psimd_lane #(.W(HalfW)) u_lane (
      .a_i   (in_i.operand_a[h*HalfW +: HalfW]),
      .b_i   (in_i.operand_b[h*HalfW +: HalfW]),
      .ctrl_i(ctrl),
      .res_o (half_res[h*HalfW +: HalfW]),
      .ge_o  (half_ge[h])
    );
    assign half_ge_wide[h*(HalfW/ByteW) +: (HalfW/ByteW)] = {(HalfW/ByteW){half_ge[h]}};
  end

  // result assembly; unknown codes give all zeros
  always_comb begin
    out_o = '0;
    if (func_known) begin
      out_o.packed_result = in_i.lane_is_halfword ? half_res : byte_res;
      out_o.ge_valid      = plain;
      if (plain) begin
        out_o.ge_flags = in_i.lane_is_halfword ? half_ge_wide : byte_ge;
      end
    end
  end

endmodule

// ===== rtl/packed_simd_add_sub_alu.sv =====
// ----------------------------------------------------------------------------
// packed_simd_add_sub_alu: packed SIMD add/subtract unit
// Byte and halfword lane add, subtract, halving and saturating operations
// on two packed 32-bit operands, with per-byte GE flags.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a rising edge with start_i high and busy_o
//   low. busy_o never rises: the unit takes one transaction every cycle.
//   in_i carries the operation, lane width, signedness and both operands.
//   The transaction is captured in an input register, the lane logic works
//   between that register and the result register, and the result appears
//   on result_o with valid_o high for exactly one cycle, at the end of which
//   the receiver takes it.
//   Throughput is one transaction per cycle, set by the single
//   register-to-register pass through the lane adders.
//   The receiver cannot stall; each result must be taken in its strobe
//   cycle. Results leave in acceptance order.
//   Reset clears the valid bits of both register stages, so no result is
//   strobed for anything in flight at reset; payload registers keep
//   whatever they held.
// ----------------------------------------------------------------------------
module packed_simd_add_sub_alu
  import psimd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  psimd_in_t  in_i,
  output logic       valid_o,
  output psimd_out_t result_o
);

  logic       in_valid_d, in_valid_q;
  psimd_in_t  in_d, in_q;
  logic       res_valid_d, res_valid_q;
  psimd_out_t res_d, res_q;

  assign busy_o = 1'b0;

  // input stage
  assign in_valid_d = start_i && !busy_o;
  assign in_d       = in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_q <= in_d;
    end
  end

  // lane logic
  psimd_datapath u_datapath (
    .in_i (in_q),
    .out_o(res_d)
  );

  // result stage
  assign res_valid_d = in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

  // every accepted transaction is strobed once it has passed the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 valid_o)
    else $error("accepted transaction produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 2))
    else $error("result strobed without an accepted transaction");

  // flags only come with plain add or subtract
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !result_o.ge_valid) |-> (result_o.ge_flags == '0))
    else $error("GE flags set for an operation without flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(in_i.func, 2) > FUNC_QSUB))
      |-> (result_o == '0))
    else $error("unknown operation gave a nonzero result");

endmodule

// ===== tb/packed_simd_lane_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_simd_lane_checker: result checker for the packed SIMD add/sub ALU
// Watches the command and result channels. Every accepted transaction is
// run through a lane-level arithmetic predictor and the expected result is
// queued. Each strobed result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module packed_simd_lane_checker
  import psimd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  psimd_in_t   in_i,
  input  logic        valid_i,
  input  psimd_out_t  result_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  psimd_out_t  lane_result_q[$];
  int unsigned mismatch_cnt;

  assign mismatches_o = mismatch_cnt;

  // Exact per-lane sum or difference, then wrap, floor-halve or clamp.
  function automatic psimd_out_t lane_arith_result(psimd_in_t t);
    psimd_out_t  r;
    psimd_mode_e mode;
    logic        is_sub;
    logic        flag;
    int          lw, nl, span, lo, hi;
    int          x, y, exact, val;
    r = '0;
    case (t.func)
      FUNC_ADD, FUNC_SUB:   mode = MODE_WRAP;
      FUNC_HADD, FUNC_HSUB: mode = MODE_HALVE;
      FUNC_QADD, FUNC_QSUB: mode = MODE_SAT;
      // unknown operation: all-zero result
      default: return r;
    endcase
    is_sub = (t.func == FUNC_SUB) || (t.func == FUNC_HSUB) || (t.func == FUNC_QSUB);
    lw   = t.lane_is_halfword ? int'(HalfW) : int'(ByteW);
    nl   = int'(DataW) / lw;
    span = 1 << lw;
    lo   = t.lanes_signed ? -(span / 2) : 0;
    hi   = t.lanes_signed ? (span / 2 - 1) : (span - 1);
    for (int i = 0; i < nl; i++) begin
      x = int'((t.operand_a >> (i * lw)) & (span - 1));
      y = int'((t.operand_b >> (i * lw)) & (span - 1));
      if (t.lanes_signed && x > hi) x -= span;
      if (t.lanes_signed && y > hi) y -= span;
      exact = is_sub ? (x - y) : (x + y);
      case (mode)
        MODE_WRAP: begin
          val = exact;
          // unsigned add: carry out; everything else: exact result >= 0
          flag = (!t.lanes_signed && !is_sub) ? (exact >= span) : (exact >= 0);
          if (flag) begin
            if (t.lane_is_halfword) r.ge_flags[2*i +: 2] = 2'b11;
            else r.ge_flags[i] = 1'b1;
          end
        end
        MODE_HALVE: val = exact >>> 1;
        default:    val = (exact < lo) ? lo : ((exact > hi) ? hi : exact);
      endcase
      r.packed_result |= (32'(val) & 32'(span - 1)) << (i * lw);
    end
    // flags only exist for plain add and sub
    r.ge_valid = (mode == MODE_WRAP);
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
  endtask

  // pop and compare on each result strobe, queue a prediction per transaction
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    psimd_out_t want;
    if (!rst_ni) begin
      lane_result_q.delete();
      mismatch_cnt = 0;
      pending_o <= 0;
    end else begin
      if (valid_i) begin
        if (lane_result_q.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got %h/%h/%b",
                   $time, result_i.packed_result, result_i.ge_flags, result_i.ge_valid);
          mismatch_cnt++;
        end else begin
          want = lane_result_q.pop_front();
          if (result_i.packed_result !== want.packed_result) begin
            report_field("packed_result", want.packed_result, result_i.packed_result);
            mismatch_cnt++;
          end
          if (result_i.ge_flags !== want.ge_flags) begin
            report_field("ge_flags", 32'(want.ge_flags), 32'(result_i.ge_flags));
            mismatch_cnt++;
          end
          if (result_i.ge_valid !== want.ge_valid) begin
            report_field("ge_valid", 32'(want.ge_valid), 32'(result_i.ge_valid));
            mismatch_cnt++;
          end
        end
      end
      if (start_i && !busy_i) lane_result_q.push_back(lane_arith_result(in_i));
      pending_o <= lane_result_q.size();
    end
  end

endmodule

// ===== tb/packed_simd_add_sub_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_simd_add_sub_alu_tb: testbench for the packed SIMD add/sub ALU
// Drives a directed sweep of every operation, lane width and signedness with
// lane-extreme operands, then random transactions with lane-edge values and
// random idle gaps. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module packed_simd_add_sub_alu_tb;
  import psimd_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 10;
  localparam int RandomItems = 400;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 4;
  localparam int IdlePct     = 23;

  // operation codes outside the defined set
  localparam logic [2:0] FuncRsvdLo = 3'd6;
  localparam logic [2:0] FuncRsvdHi = 3'd7;

  // directed operand pairs: carries, borrows, sign boundaries
  localparam logic [31:0] DirA [6] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7F80_7F80,
                                       32'h8000_7FFF, 32'h7FFF_8000, 32'h0180_FF7F};
  localparam logic [31:0] DirB [6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7F80_807F,
                                       32'h7FFF_8000, 32'h8000_0001, 32'h0180_017F};

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  psimd_in_t   stim  = '0;
  logic        busy;
  logic        valid;
  psimd_out_t  result;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycles = 0;

  packed_simd_add_sub_alu i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .busy_o   (busy),
    .in_i     (stim),
    .valid_o  (valid),
    .result_o (result)
  );

  packed_simd_lane_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (stim),
    .valid_i      (valid),
    .result_i     (result),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("packed_simd_add_sub_alu_tb: done, errors");
    $finish;
  end

  // random word, often built from byte lane edge values
  function automatic logic [31:0] lane_edge_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(2) == 0) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(6))
          0: w[8*i +: 8] = 8'h00;
          1: w[8*i +: 8] = 8'h01;
          2: w[8*i +: 8] = 8'h7F;
          3: w[8*i +: 8] = 8'h80;
          4: w[8*i +: 8] = 8'hFE;
          5: w[8*i +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // present one transaction and hold it until accepted; start stays high
  task automatic send_op(psimd_in_t t);
    start <= 1'b1;
    stim  <= t;
    do @(posedge clk); while (busy);
  endtask

  // stop issuing until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    psimd_in_t t;
    int        k;
    logic      idle_ok;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation x lane width x signedness, then unknown ops
    k = 0;
    for (int f = int'(FUNC_ADD); f <= int'(FUNC_QSUB); f++) begin
      for (int m = 0; m < 4; m++) begin
        t.func             = 3'(f);
        t.lane_is_halfword = m[0];
        t.lanes_signed     = m[1];
        t.operand_a        = DirA[k % 6];
        t.operand_b        = DirB[k % 6];
        send_op(t);
        k++;
      end
    end
    t.func = FuncRsvdLo;
    t.operand_a = 32'hFFFF_FFFF;
    t.operand_b = 32'hFFFF_FFFF;
    send_op(t);
    t.func = FuncRsvdHi;
    t.lane_is_halfword = 1'b0;
    t.operand_a = 32'h8080_8080;
    send_op(t);
    wait_drained();

    // random transactions
    for (int n = 0; n < RandomItems; n++) begin
      idle_ok = (n < 120) || (n >= 220);
      if (idle_ok) begin
        while ($urandom_range(99) < IdlePct) begin
          start <= 1'b0;
          stim.operand_a <= $urandom();
          stim.operand_b <= $urandom();
          @(posedge clk);
        end
      end
      if ($urandom_range(49) == 0) t.func = $urandom_range(1) ? FuncRsvdHi : FuncRsvdLo;
      else t.func = 3'($urandom_range(int'(FUNC_QSUB)));
      t.lane_is_halfword = 1'($urandom_range(1));
      t.lanes_signed     = 1'($urandom_range(1));
      t.operand_a        = lane_edge_word();
      t.operand_b        = lane_edge_word();
      send_op(t);
      if (n == RandomItems / 2) wait_drained();
    end

    // let the pipeline empty, then watch for stray strobes
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("packed_simd_add_sub_alu_tb: done, clean");
    end else begin
      $display("packed_simd_add_sub_alu_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psimd_pkg.sv
rtl/psimd_lane.sv
rtl/psimd_datapath.sv
rtl/packed_simd_add_sub_alu.sv
tb/packed_simd_lane_checker.sv
tb/packed_simd_add_sub_alu_tb.sv
